// File: sv/khcc_pkg.sv
package khcc_pkg;
  localparam int HIT_DEPTH_DEF = 64;
  localparam int POS_BITS_DEF = 20;
  localparam int MAX_BLOCKS = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINHITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MINSPAN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP = 3'd4;

  typedef struct packed {
    logic [19:0] jump_limit;
    logic [19:0] drift_limit;
    logic [6:0]  chain_min_hits;
    logic [19:0] chain_min_span;
    logic [5:0]  hit_group_limit;
  } cfg_t;

  typedef struct packed {
    logic        block_valid;
    logic [31:0] read_id;
    logic [31:0] node_id;
    logic [19:0] query_start;
    logic [19:0] query_end;
    logic [19:0] target_start;
    logic [19:0] target_end;
    logic [6:0]  chain_score;
    logic        overflow;
    logic        last_block;
  } blk_t;
endpackage

// File: sv/khcc_front.sv
// Front: loads hits into the store, then hands the closed set to the back end.
module khcc_front import khcc_pkg::*; #(
  parameter int HIT_DEPTH = HIT_DEPTH_DEF,
  parameter int POS_BITS = POS_BITS_DEF,
  localparam int AW = $clog2(HIT_DEPTH),
  localparam int CW = $clog2(HIT_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [19:0]         in_query_pos,
  input  logic [19:0]         in_target_pos,
  input  logic signed [31:0]  in_node_id,
  input  logic [31:0]         in_read_id,
  input  logic                in_last_hit,
  output logic                we,
  output logic [AW-1:0]       waddr,
  output logic [POS_BITS-1:0] wq,
  output logic [POS_BITS-1:0] wt,
  output logic                set_valid,
  input  logic                set_take,
  output logic [CW-1:0]       set_count,
  output logic [31:0]         set_node,
  output logic [31:0]         set_read,
  output logic                set_ovf
);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt, pend_r, pend_nxt;
  logic [31:0] node_r, read_r;
  logic acc;
  logic [POS_BITS-1:0] qx, tx;

  always_comb begin
    qx = '0;
    tx = '0;
    qx[((POS_BITS < 20) ? POS_BITS : 20)-1:0] =
      in_query_pos[((POS_BITS < 20) ? POS_BITS : 20)-1:0];
    tx[((POS_BITS < 20) ? POS_BITS : 20)-1:0] =
      in_target_pos[((POS_BITS < 20) ? POS_BITS : 20)-1:0];
  end

  // one closed set can wait in the hand-off slot while the back end chains
  assign in_ready = !pend_r;
  assign acc = in_valid && in_ready;
  assign we = acc && (cnt_r < CW'(HIT_DEPTH));
  assign waddr = cnt_r[AW-1:0];
  assign wq = qx;
  assign wt = tx;
  assign set_valid = pend_r;
  assign set_count = cnt_r;
  assign set_node = node_r;
  assign set_read = read_r;
  assign set_ovf = ovf_r;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    pend_nxt = pend_r;
    if (acc) begin
      if (we) cnt_nxt = cnt_r + CW'(1);
      else ovf_nxt = 1'b1;
      if (in_last_hit) pend_nxt = 1'b1;
    end
    if (set_take) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      pend_r <= 1'b0;
      node_r <= '0;
      read_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      pend_r <= pend_nxt;
      if (acc) begin
        node_r <= in_node_id;
        read_r <= in_read_id;
      end
    end
  end
endmodule

// File: sv/khcc_back.sv
// Back: group filter pass, then greedy chain scans; results go via a hold and an output register.
module khcc_back import khcc_pkg::*; #(
  parameter int HIT_DEPTH = HIT_DEPTH_DEF,
  parameter int POS_BITS = POS_BITS_DEF,
  localparam int AW = $clog2(HIT_DEPTH),
  localparam int CW = $clog2(HIT_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [POS_BITS-1:0] wq,
  input  logic [POS_BITS-1:0] wt,
  input  logic                set_valid,
  output logic                set_take,
  input  logic [CW-1:0]       set_count,
  input  logic [31:0]         set_node,
  input  logic [31:0]         set_read,
  input  logic                set_ovf,
  output logic                res_valid,
  input  logic                res_ready,
  output blk_t                res
);
  localparam logic [3:0] S_IDLE = 4'd0, S_GRD = 4'd1, S_GRW = 4'd2, S_GMARK = 4'd3,
                         S_SRD = 4'd4, S_SWAIT = 4'd5, S_SCAN = 4'd6, S_EMIT = 4'd7,
                         S_NONE = 4'd8, S_FIN = 4'd9, S_SRW = 4'd10;
  localparam int DW = ((POS_BITS > 20) ? POS_BITS : 20) + 2;

  logic [POS_BITS-1:0] mq [HIT_DEPTH];
  logic [POS_BITS-1:0] mt [HIT_DEPTH];
  logic [HIT_DEPTH-1:0] used_r;
  logic [POS_BITS-1:0] rq_r, rt_r;
  logic [AW-1:0] raddr;

  logic [3:0] st_r;
  logic [CW-1:0] gs_r, ge_r, i_r, s_r, mk_r;
  logic [POS_BITS-1:0] gq_r, pt_r;
  logic gdrop_r;
  logic [POS_BITS-1:0] sp_r, st0_r, lp_r, lt_r;
  logic [6:0] len_r;
  logic [6:0] nres_r;
  logic pend_r;
  blk_t pb_r;
  logic [CW:0] gsz;
  // finished block waits here until the next one (or set end) decides last_block
  logic hv_r;
  blk_t hb_r;
  logic keep, out_free, ld_out;
  blk_t ld_blk;

  always_ff @(posedge clk) begin
    if (we) begin
      mq[waddr] <= wq;
      mt[waddr] <= wt;
    end
    rq_r <= mq[raddr];
    rt_r <= mt[raddr];
  end

  always_comb begin
    case (st_r)
      S_GRD, S_GRW: raddr = i_r[AW-1:0];
      S_SRD, S_SWAIT, S_SCAN, S_SRW: raddr = i_r[AW-1:0];
      default: raddr = '0;
    endcase
  end

  // chain join test against the last chained hit
  logic signed [DW-1:0] ld, hd, dd, qg, tg;
  logic join_ok, stop_scan;
  always_comb begin
    ld = DW'($signed({2'b0, lt_r})) - DW'($signed({2'b0, lp_r}));
    hd = DW'($signed({2'b0, rt_r})) - DW'($signed({2'b0, rq_r}));
    dd = ld - hd;
    if (dd < 0) dd = -dd;
    qg = DW'($signed({2'b0, rq_r})) - DW'($signed({2'b0, lp_r}));
    tg = DW'($signed({2'b0, rt_r})) - DW'($signed({2'b0, lt_r}));
    stop_scan = qg > $signed({{(DW-20){1'b0}}, cfg.jump_limit});
    join_ok = !used_r[i_r[AW-1:0]] && (rq_r >= lp_r) && (rt_r >= lt_r) &&
              (tg <= $signed({{(DW-20){1'b0}}, cfg.jump_limit})) &&
              (dd <= $signed({{(DW-20){1'b0}}, cfg.drift_limit}));
  end

  logic signed [DW-1:0] spacing;
  assign spacing = DW'($signed({2'b0, rt_r})) - DW'($signed({2'b0, pt_r}));
  assign gsz = {1'b0, ge_r} - {1'b0, gs_r};
  assign set_take = (st_r == S_FIN);
  assign res_valid = pend_r;
  assign res = pb_r;

  logic [POS_BITS-1:0] span;
  assign span = lp_r - sp_r;

  assign keep = (len_r >= cfg.chain_min_hits) &&
                ({{(DW-POS_BITS){1'b0}}, span} >= {{(DW-20){1'b0}}, cfg.chain_min_span}) &&
                (nres_r < 7'(MAX_BLOCKS));
  assign out_free = !pend_r || res_ready;

  // output register loads: held block when a newer one arrives, held block
  // flagged last at set end, or the empty-set result
  always_comb begin
    ld_out = 1'b0;
    ld_blk = hb_r;
    case (st_r)
      S_EMIT: ld_out = keep && hv_r && out_free;
      S_SRD: if (s_r >= set_count && hv_r && out_free) begin
        ld_out = 1'b1;
        ld_blk.last_block = 1'b1;
      end
      S_NONE: if (out_free) begin
        ld_out = 1'b1;
        ld_blk = '{1'b0, set_read, set_node, 20'd0, 20'd0, 20'd0, 20'd0, 7'd0,
                   set_ovf, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (ld_out) begin
      pend_r <= 1'b1;
      pb_r <= ld_blk;
    end else if (res_ready) begin
      pend_r <= 1'b0;
    end
  end

  function automatic logic [19:0] p20(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+19:0] w;
    w = {20'b0, v};
    return w[19:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      used_r <= '0;
      nres_r <= '0;
      hv_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (set_valid) begin
          i_r <= '0;
          gs_r <= '0;
          nres_r <= '0;
          st_r <= (set_count == '0) ? S_NONE : S_GRD;
        end
        S_GRD: st_r <= S_GRW;   // read of the hit at i_r (group head or follower candidate)
        S_GRW: begin
          // i_r == gs_r: group start; else a follower candidate
          if (i_r == gs_r) begin
            gq_r <= rq_r;
            pt_r <= rt_r;
            gdrop_r <= 1'b0;
            ge_r <= gs_r;
            if (i_r + CW'(1) < set_count) begin
              i_r <= i_r + CW'(1);
              st_r <= S_GRD;
            end else begin
              mk_r <= gs_r;
              st_r <= S_GMARK;
            end
          end else if (rq_r == gq_r) begin
            ge_r <= i_r;
            pt_r <= rt_r;
            if (spacing < $signed({{(DW-20){1'b0}}, cfg.jump_limit})) gdrop_r <= 1'b1;
            if (i_r + CW'(1) < set_count) begin
              i_r <= i_r + CW'(1);
              st_r <= S_GRD;
            end else begin
              mk_r <= gs_r;
              st_r <= S_GMARK;
            end
          end else begin
            mk_r <= gs_r;
            st_r <= S_GMARK;
          end
        end
        S_GMARK: begin
          if (gdrop_r || gsz > (CW+1)'(cfg.hit_group_limit)) used_r[mk_r[AW-1:0]] <= 1'b1;
          if (mk_r < ge_r) mk_r <= mk_r + CW'(1);
          else if (ge_r + CW'(1) < set_count) begin
            gs_r <= ge_r + CW'(1);
            i_r <= ge_r + CW'(1);
            st_r <= S_GRD;
          end else begin
            s_r <= '0;
            i_r <= '0;
            st_r <= S_SRD;
          end
        end
        S_SRD: begin
          if (s_r >= set_count) begin
            if (!hv_r) st_r <= S_NONE;
            else if (out_free) begin
              hv_r <= 1'b0;
              st_r <= S_FIN;
            end
          end else if (used_r[s_r[AW-1:0]]) begin
            s_r <= s_r + CW'(1);
            i_r <= s_r + CW'(1);
          end else begin
            i_r <= s_r;
            st_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          sp_r <= rq_r;
          lp_r <= rq_r;
          st0_r <= rt_r;
          lt_r <= rt_r;
          len_r <= 7'd1;
          used_r[s_r[AW-1:0]] <= 1'b1;
          if (s_r + CW'(1) < set_count) begin
            i_r <= s_r + CW'(1);
            st_r <= S_SRW;
          end else st_r <= S_EMIT;
        end
        S_SRW: st_r <= S_SCAN;
        S_SCAN: begin
          if (stop_scan) st_r <= S_EMIT;
          else begin
            if (join_ok) begin
              if (len_r != 7'd127) len_r <= len_r + 7'd1;
              lp_r <= rq_r;
              lt_r <= rt_r;
              used_r[i_r[AW-1:0]] <= 1'b1;
            end
            if (i_r + CW'(1) < set_count) begin
              i_r <= i_r + CW'(1);
              st_r <= S_SRW;
            end else st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (keep) begin
            if (!hv_r || out_free) begin
              hv_r <= 1'b1;
              hb_r <= '{1'b1, set_read, set_node, p20(sp_r), p20(lp_r), p20(st0_r),
                        p20(lt_r), len_r, set_ovf, 1'b0};
              nres_r <= nres_r + 7'd1;
              s_r <= s_r + CW'(1);
              i_r <= s_r + CW'(1);
              st_r <= S_SRD;
            end
          end else begin
            s_r <= s_r + CW'(1);
            i_r <= s_r + CW'(1);
            st_r <= S_SRD;
          end
        end
        S_NONE: if (out_free) begin
          st_r <= S_FIN;
          nres_r <= 7'd1;
        end
        S_FIN: begin
          used_r <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/kmer_hit_colinear_chainer.sv
// Channel   | Ports                                    | Moves
// in        | in_valid/in_ready + hit fields           | one hit request
// out       | out_valid/out_ready + block fields       | one block request
// cfg       | cfg_we, cfg_index, cfg_data              | register write
// Hits load one per cycle while in_ready is high. After the closing hit, the group
// pass reads each hit, rereads each group's head, and marks each hit in turn.
// Each chain start reads its head, then rescans each later hit in turn (one store
// read port) up to the query-gap stop; a used hit is skipped in S_SRD.
// A block waits in a hold register until the next block or set end fixes its
// last flag, then in the output register; the set's last result must be taken
// before the next set's hits are accepted. Reset is synchronous; no clearing pass.
module kmer_hit_colinear_chainer import khcc_pkg::*; #(
  parameter int HIT_DEPTH = HIT_DEPTH_DEF,
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [19:0]           in_query_pos,
  input  logic [19:0]           in_target_pos,
  input  logic signed [31:0]    in_node_id,
  input  logic [31:0]           in_read_id,
  input  logic                  in_last_hit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_block_valid,
  output logic [31:0]           out_block_read_id,
  output logic signed [31:0]    out_block_node_id,
  output logic [19:0]           out_query_start,
  output logic [19:0]           out_query_end,
  output logic [19:0]           out_target_start,
  output logic [19:0]           out_target_end,
  output logic [6:0]            out_chain_score,
  output logic                  out_overflow,
  output logic                  out_last_block,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = $clog2(HIT_DEPTH);
  localparam int CW = $clog2(HIT_DEPTH + 1);

  cfg_t cfg_r;
  logic we, set_valid, set_take, set_ovf, fin_ok;
  logic [AW-1:0] waddr;
  logic [POS_BITS-1:0] wq, wt;
  logic [CW-1:0] set_count;
  logic [31:0] set_node, set_read;
  blk_t res;
  logic rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{20'd500, 20'd60, 7'd2, 20'd1000, 6'd5};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_JUMP:    cfg_r.jump_limit <= cfg_data;
        REG_DRIFT:   cfg_r.drift_limit <= cfg_data;
        REG_MINHITS: cfg_r.chain_min_hits <= cfg_data[6:0];
        REG_MINSPAN: cfg_r.chain_min_span <= cfg_data;
        REG_GROUP:   cfg_r.hit_group_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // held last block must go before the store is reused
  assign fin_ok = !(out_valid && out_last_block);
  assign in_ready = rdy_f && fin_ok;

  khcc_front #(.HIT_DEPTH(HIT_DEPTH), .POS_BITS(POS_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_valid && fin_ok), .in_ready(rdy_f),
    .in_query_pos, .in_target_pos, .in_node_id, .in_read_id, .in_last_hit,
    .we, .waddr, .wq, .wt, .set_valid, .set_take, .set_count, .set_node,
    .set_read, .set_ovf
  );

  khcc_back #(.HIT_DEPTH(HIT_DEPTH), .POS_BITS(POS_BITS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .we, .waddr, .wq, .wt, .set_valid, .set_take,
    .set_count, .set_node, .set_read, .set_ovf, .res_valid(out_valid),
    .res_ready(out_ready), .res
  );

  assign out_block_valid = res.block_valid;
  assign out_block_read_id = res.read_id;
  assign out_block_node_id = res.node_id;
  assign out_query_start = res.query_start;
  assign out_query_end = res.query_end;
  assign out_target_start = res.target_start;
  assign out_target_end = res.target_end;
  assign out_chain_score = res.chain_score;
  assign out_overflow = res.overflow;
  assign out_last_block = res.last_block;
endmodule

// File: sv/khcc_checker.sv
module khcc_checker import khcc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_block_valid,
  input logic out_last_block,
  input logic [6:0] out_chain_score
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_block_valid |-> out_last_block) else $error("empty not last");
  a_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_valid |-> out_chain_score != 7'd0) else $error("zero score");
  a_noload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_block |-> !in_ready) else $error("load during last");
endmodule

bind kmer_hit_colinear_chainer khcc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_block_valid,
  .out_last_block, .out_chain_score
);
